// ----- hdl/lpg_pkg.sv -----
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared types and constants for the lidar point gate: register indexes,
// reset values, control-word fields and rejection reason codes.
// ----------------------------------------------------------------------------
package lpg_pkg;

    // Configuration register file
    localparam int unsigned CFG_IDX_WIDTH  = 3;
    localparam int unsigned CFG_DATA_WIDTH = 48;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_MIN_RANGE_SQ  = 3'd0,
        REG_MAX_RANGE_SQ  = 3'd1,
        REG_Z_WINDOW      = 3'd2,
        REG_CONTROL_WORD  = 3'd3,
        REG_BODY_BOX_LOW  = 3'd4,
        REG_BODY_BOX_HIGH = 3'd5,
        REG_HOOD_BOX_LOW  = 3'd6,
        REG_HOOD_BOX_HIGH = 3'd7
    } t_reg_index;

    localparam int unsigned RANGE_WIDTH = 32;
    localparam int unsigned ZWIN_WIDTH  = 32;
    localparam int unsigned CTRL_WIDTH  = 19;
    localparam int unsigned BOX_WIDTH   = 48;
    localparam int unsigned BOUND_WIDTH = 16;   // one signed axis bound

    localparam logic [RANGE_WIDTH-1:0] MIN_RANGE_SQ_RST = 32'd10000;
    localparam logic [RANGE_WIDTH-1:0] MAX_RANGE_SQ_RST = 32'd36000000;
    localparam logic [ZWIN_WIDTH-1:0]  Z_WINDOW_RST     = 32'd19726036; // -300 .. 300
    localparam logic [CTRL_WIDTH-1:0]  CONTROL_WORD_RST = 19'd65541;    // eps 5, origin on
    localparam logic [BOX_WIDTH-1:0]   BOX_RST          = 48'd0;

    // Control word fields
    localparam int unsigned CTRL_EPS_WIDTH  = 16;
    localparam int unsigned CTRL_ORIGIN_BIT = 16;
    localparam int unsigned CTRL_BODY_BIT   = 17;
    localparam int unsigned CTRL_HOOD_BIT   = 18;

    // Rejection reasons, first failing check wins
    typedef enum logic [2:0] {
        RSN_KEPT      = 3'd0,
        RSN_NONFINITE = 3'd1,
        RSN_ORIGIN    = 3'd2,
        RSN_RANGE     = 3'd3,
        RSN_Z         = 3'd4,
        RSN_BOX       = 3'd5
    } t_reason;

    // Per-point check results carried from the compare stage to the result stage
    typedef struct packed {
        logic nonfinite;
        logic origin_hit;
        logic z_fail;
        logic box_hit;
    } t_check_flags;

endpackage

// ----- hdl/lidar_point_gate_top.sv -----
// ----------------------------------------------------------------------------
// lidar_point_gate_top
// Per-point lidar gate: non-finite, origin cube, squared-range window,
// z window and two exclusion boxes, reporting keep and the first reason.
// ----------------------------------------------------------------------------
// The gate takes one point beat per clock while o_stall is low and returns
// exactly one result beat per point, in order. A point passes three register
// stages (input capture, squaring and bound compares, range sum and reason
// select) on its way out; throughput is one point per cycle while the output
// is not stalled. Each stage advances whenever it is empty or its
// successor advances, so bubbles are squeezed out and a new point is taken
// while a finished result waits on a stalled consumer. Checks apply in fixed
// order and all bounds are inclusive; the coordinates pass through unchanged
// for kept and rejected points alike. Write configuration only while the
// pipeline is empty: the stages read the registers live.
// ----------------------------------------------------------------------------
module lidar_point_gate_top #(
    parameter int unsigned COORD_WIDTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [lpg_pkg::CFG_IDX_WIDTH-1:0]     i_cfg_index,
    input  logic [lpg_pkg::CFG_DATA_WIDTH-1:0]    i_cfg_wdata,
    // point input channel
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [COORD_WIDTH-1:0]         i_px,
    input  logic signed [COORD_WIDTH-1:0]         i_py,
    input  logic signed [COORD_WIDTH-1:0]         i_pz,
    input  logic                                  i_is_finite,
    // result output channel
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic                                  o_keep,
    output logic [2:0]                            o_reject_reason,
    output logic signed [COORD_WIDTH-1:0]         o_qx,
    output logic signed [COORD_WIDTH-1:0]         o_qy,
    output logic signed [COORD_WIDTH-1:0]         o_qz
);

    // Compare width: wide enough for a coordinate and for a 16-bit bound.
    localparam int unsigned EW   = (COORD_WIDTH > lpg_pkg::BOUND_WIDTH) ?
                                   COORD_WIDTH : lpg_pkg::BOUND_WIDTH;
    localparam int unsigned SQW  = 2 * COORD_WIDTH;
    localparam int unsigned SUMW = SQW + 2;
    localparam int unsigned CMPW = (SUMW > lpg_pkg::RANGE_WIDTH) ?
                                   SUMW : lpg_pkg::RANGE_WIDTH;
    localparam int unsigned BW   = lpg_pkg::BOUND_WIDTH;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [lpg_pkg::RANGE_WIDTH-1:0] r_min_range_sq;
    logic [lpg_pkg::RANGE_WIDTH-1:0] r_max_range_sq;
    logic [lpg_pkg::ZWIN_WIDTH-1:0]  r_z_window;
    logic [lpg_pkg::CTRL_WIDTH-1:0]  r_control_word;
    logic [lpg_pkg::BOX_WIDTH-1:0]   r_body_box_low;
    logic [lpg_pkg::BOX_WIDTH-1:0]   r_body_box_high;
    logic [lpg_pkg::BOX_WIDTH-1:0]   r_hood_box_low;
    logic [lpg_pkg::BOX_WIDTH-1:0]   r_hood_box_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_range_sq  <= lpg_pkg::MIN_RANGE_SQ_RST;
            r_max_range_sq  <= lpg_pkg::MAX_RANGE_SQ_RST;
            r_z_window      <= lpg_pkg::Z_WINDOW_RST;
            r_control_word  <= lpg_pkg::CONTROL_WORD_RST;
            r_body_box_low  <= lpg_pkg::BOX_RST;
            r_body_box_high <= lpg_pkg::BOX_RST;
            r_hood_box_low  <= lpg_pkg::BOX_RST;
            r_hood_box_high <= lpg_pkg::BOX_RST;
        end else if (i_cfg_we) begin
            // truncate the write data to each register's width
            case (lpg_pkg::t_reg_index'(i_cfg_index))
                lpg_pkg::REG_MIN_RANGE_SQ:  r_min_range_sq  <= i_cfg_wdata[lpg_pkg::RANGE_WIDTH-1:0];
                lpg_pkg::REG_MAX_RANGE_SQ:  r_max_range_sq  <= i_cfg_wdata[lpg_pkg::RANGE_WIDTH-1:0];
                lpg_pkg::REG_Z_WINDOW:      r_z_window      <= i_cfg_wdata[lpg_pkg::ZWIN_WIDTH-1:0];
                lpg_pkg::REG_CONTROL_WORD:  r_control_word  <= i_cfg_wdata[lpg_pkg::CTRL_WIDTH-1:0];
                lpg_pkg::REG_BODY_BOX_LOW:  r_body_box_low  <= i_cfg_wdata[lpg_pkg::BOX_WIDTH-1:0];
                lpg_pkg::REG_BODY_BOX_HIGH: r_body_box_high <= i_cfg_wdata[lpg_pkg::BOX_WIDTH-1:0];
                lpg_pkg::REG_HOOD_BOX_LOW:  r_hood_box_low  <= i_cfg_wdata[lpg_pkg::BOX_WIDTH-1:0];
                lpg_pkg::REG_HOOD_BOX_HIGH: r_hood_box_high <= i_cfg_wdata[lpg_pkg::BOX_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage enables: a stage advances when it is empty or its successor
    // advances. The output stage advances when empty or when the consumer
    // takes the beat.
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;

    assign en3     = !r_v3 || !i_stall;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture the point beat
    // ------------------------------------------------------------------
    logic signed [COORD_WIDTH-1:0] r1_px, r1_py, r1_pz;
    logic                          r1_fin;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_px  <= i_px;
            r1_py  <= i_py;
            r1_pz  <= i_pz;
            r1_fin <= i_is_finite;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: magnitudes, squares and all bound compares but range
    // ------------------------------------------------------------------
    logic [COORD_WIDTH-1:0]  mag_x, mag_y, mag_z;
    logic [SQW-1:0]          n_sq_x, n_sq_y, n_sq_z;
    logic signed [EW-1:0]    ex_x, ex_y, ex_z;
    logic signed [EW-1:0]    z_min, z_max;
    logic [EW-1:0]           eps;
    logic                    body_in, hood_in;
    lpg_pkg::t_check_flags   n_flags;

    // |v| fits in COORD_WIDTH unsigned bits, the most negative value too
    assign mag_x = r1_px[COORD_WIDTH-1] ? (~r1_px + 1'b1) : r1_px;
    assign mag_y = r1_py[COORD_WIDTH-1] ? (~r1_py + 1'b1) : r1_py;
    assign mag_z = r1_pz[COORD_WIDTH-1] ? (~r1_pz + 1'b1) : r1_pz;

    assign n_sq_x = SQW'(mag_x) * SQW'(mag_x);
    assign n_sq_y = SQW'(mag_y) * SQW'(mag_y);
    assign n_sq_z = SQW'(mag_z) * SQW'(mag_z);

    // sign-extend point and bounds to a common compare width
    assign ex_x  = EW'(r1_px);
    assign ex_y  = EW'(r1_py);
    assign ex_z  = EW'(r1_pz);
    assign z_min = EW'($signed(r_z_window[BW-1:0]));
    assign z_max = EW'($signed(r_z_window[2*BW-1:BW]));
    assign eps   = EW'(r_control_word[lpg_pkg::CTRL_EPS_WIDTH-1:0]);

    // box containment; an inverted axis never contains a point
    always_comb begin
        body_in = 1'b1;
        hood_in = 1'b1;
        if (ex_x < EW'($signed(r_body_box_low[BW-1:0]))      ||
            ex_x > EW'($signed(r_body_box_high[BW-1:0]))     ||
            ex_y < EW'($signed(r_body_box_low[2*BW-1:BW]))   ||
            ex_y > EW'($signed(r_body_box_high[2*BW-1:BW]))  ||
            ex_z < EW'($signed(r_body_box_low[3*BW-1:2*BW])) ||
            ex_z > EW'($signed(r_body_box_high[3*BW-1:2*BW]))) begin
            body_in = 1'b0;
        end
        if (ex_x < EW'($signed(r_hood_box_low[BW-1:0]))      ||
            ex_x > EW'($signed(r_hood_box_high[BW-1:0]))     ||
            ex_y < EW'($signed(r_hood_box_low[2*BW-1:BW]))   ||
            ex_y > EW'($signed(r_hood_box_high[2*BW-1:BW]))  ||
            ex_z < EW'($signed(r_hood_box_low[3*BW-1:2*BW])) ||
            ex_z > EW'($signed(r_hood_box_high[3*BW-1:2*BW]))) begin
            hood_in = 1'b0;
        end
    end

    always_comb begin
        n_flags.nonfinite  = !r1_fin;
        n_flags.origin_hit = r_control_word[lpg_pkg::CTRL_ORIGIN_BIT] &&
                             (EW'(mag_x) <= eps) && (EW'(mag_y) <= eps) &&
                             (EW'(mag_z) <= eps);
        n_flags.z_fail     = (ex_z < z_min) || (ex_z > z_max);
        n_flags.box_hit    = (r_control_word[lpg_pkg::CTRL_BODY_BIT] && body_in) ||
                             (r_control_word[lpg_pkg::CTRL_HOOD_BIT] && hood_in);
    end

    logic [SQW-1:0]                r2_sq_x, r2_sq_y, r2_sq_z;
    lpg_pkg::t_check_flags         r2_flags;
    logic signed [COORD_WIDTH-1:0] r2_px, r2_py, r2_pz;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_sq_x  <= n_sq_x;
            r2_sq_y  <= n_sq_y;
            r2_sq_z  <= n_sq_z;
            r2_flags <= n_flags;
            r2_px    <= r1_px;
            r2_py    <= r1_py;
            r2_pz    <= r1_pz;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: exact squared range, window compare, first-fail select
    // ------------------------------------------------------------------
    logic [SUMW-1:0]    range_sq;
    logic               range_fail;
    lpg_pkg::t_reason   n_reason;

    assign range_sq   = SUMW'(r2_sq_x) + SUMW'(r2_sq_y) + SUMW'(r2_sq_z);
    assign range_fail = (CMPW'(range_sq) < CMPW'(r_min_range_sq)) ||
                        (CMPW'(range_sq) > CMPW'(r_max_range_sq));

    always_comb begin
        if (r2_flags.nonfinite) begin
            n_reason = lpg_pkg::RSN_NONFINITE;
        end else if (r2_flags.origin_hit) begin
            n_reason = lpg_pkg::RSN_ORIGIN;
        end else if (range_fail) begin
            n_reason = lpg_pkg::RSN_RANGE;
        end else if (r2_flags.z_fail) begin
            n_reason = lpg_pkg::RSN_Z;
        end else if (r2_flags.box_hit) begin
            n_reason = lpg_pkg::RSN_BOX;
        end else begin
            n_reason = lpg_pkg::RSN_KEPT;
        end
    end

    logic                          r3_keep;
    lpg_pkg::t_reason              r3_reason;
    logic signed [COORD_WIDTH-1:0] r3_qx, r3_qy, r3_qz;

    // hold the result while the consumer stalls
    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_keep   <= (n_reason == lpg_pkg::RSN_KEPT);
            r3_reason <= n_reason;
            r3_qx     <= r2_px;
            r3_qy     <= r2_py;
            r3_qz     <= r2_pz;
        end
    end

    assign o_valid         = r_v3;
    assign o_keep          = r3_keep;
    assign o_reject_reason = r3_reason;
    assign o_qx            = r3_qx;
    assign o_qy            = r3_qy;
    assign o_qz            = r3_qz;

endmodule

// ----- hdl/lpg_checker.sv -----
// ----------------------------------------------------------------------------
// lpg_checker
// Port-level checks for the lidar point gate, bound to the top level.
// ----------------------------------------------------------------------------
module lpg_checker #(
    parameter int unsigned COORD_WIDTH = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic                          o_keep,
    input logic [2:0]                    o_reject_reason,
    input logic signed [COORD_WIDTH-1:0] o_qx,
    input logic signed [COORD_WIDTH-1:0] o_qy,
    input logic signed [COORD_WIDTH-1:0] o_qz
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_keep) &&
            $stable(o_reject_reason) && $stable(o_qx) && $stable(o_qy) && $stable(o_qz))
        else $error("result beat changed while stalled");

    // keep flag agrees with the reason code
    a_keep_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_keep == (o_reject_reason == lpg_pkg::RSN_KEPT)))
        else $error("keep flag disagrees with reason");

    // reason is one of the defined codes
    a_reason_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_reject_reason <= lpg_pkg::RSN_BOX))
        else $error("undefined reject reason");

    // an empty output stage never back-pressures the input
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output empty");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

endmodule

bind lidar_point_gate_top lpg_checker #(.COORD_WIDTH(COORD_WIDTH)) u_lpg_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_keep          (o_keep),
    .o_reject_reason (o_reject_reason),
    .o_qx            (o_qx),
    .o_qy            (o_qy),
    .o_qz            (o_qz)
);
